// File: rtl/indexed_sequence_buffer_core_defines.svh
// Assertion macros shared by the indexed sequence buffer checkers.
`ifndef INDEXED_SEQUENCE_BUFFER_CORE_DEFINES_SVH
`define INDEXED_SEQUENCE_BUFFER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define ISB_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ISB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/isb_pkg.sv
// Package with the types, codes and constants of the indexed sequence buffer.
package isb_pkg;

  localparam int DATA_W     = 32;
  localparam int POS_W      = 4;
  localparam int COUNT_W    = 5;
  localparam int CAPACITY_D = 16;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_READ   = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  localparam logic [DATA_W-1:0] NOT_FOUND = '1;

  // Broadcast control that every cell of the chain sees in the same cycle.
  typedef struct packed {
    logic              ins;
    logic              del;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] wdata;
  } cell_ctl_t;

endpackage

// File: rtl/indexed_sequence_buffer_core.sv
// Top level of the indexed sequence buffer: control, status and the cell chain.
//
// The block holds an ordered list of up to CAPACITY signed 32-bit words in a
// row of cells, one word per cell. Each transaction on the input channel
// carries an opcode (insert, read or delete), a position and a data word, and
// produces exactly one result transaction with a status, the word read and
// the entry count after the operation. An insert at a position from zero to
// the count shifts the later cells up by one, and a delete
// shifts them down; a read selects the cell at the position. A position out
// of range, or an unused opcode, answers status out-of-range with a data word
// of all ones and leaves the list unchanged; an in-range insert into a full
// list answers status full. The block takes one transaction per clock cycle:
// the whole chain updates in the cycle of acceptance and the result is
// registered, so it appears on the output the cycle after. The input is held
// off only during reset or while a result waits and out_ready is low. Only
// positions 0 to 15 can be addressed, and entry_count shows the count modulo 32.
module indexed_sequence_buffer_core
  import isb_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_D
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               opcode,
  input  logic [POS_W-1:0]         position,
  input  logic signed [DATA_W-1:0] data_in,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               status,
  output logic signed [DATA_W-1:0] data_out,
  output logic [COUNT_W-1:0]       entry_count
);

  // Width of the entry counter, which must be able to hold CAPACITY itself.
  localparam int CNT_W = $clog2(CAPACITY + 1);
  // Width used to compare positions with the count and cell indexes.
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int IDX_W = ($clog2(CAPACITY) > POS_W) ? $clog2(CAPACITY) : POS_W;
  // Only the first cells can be reached by a read, since the position is narrow.
  localparam int RD_N  = (CAPACITY < (2 ** POS_W)) ? CAPACITY : (2 ** POS_W);
  localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [DATA_W-1:0] cell_q [CAPACITY];
  logic [DATA_W-1:0] rd_word;
  logic [CMP_W-1:0]  pos_c;
  logic [CMP_W-1:0]  cnt_c;
  logic              accept;
  cell_ctl_t         ctl;
  status_t           st;
  logic [DATA_W-1:0] result_word;

  // A new transaction may enter whenever the output register is empty or is
  // being drained in this same cycle.
  assign in_ready = !rst && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  assign pos_c = CMP_W'(position);
  assign cnt_c = CMP_W'(count);

  // Read selection over the addressable cells; cells beyond the count are
  // never selected because the range check blocks those reads.
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < RD_N; i++) begin
      if (POS_W'(i) == position) begin
        rd_word = cell_q[i];
      end
    end
  end

  // Decode the operation, check the range first and then the fill level, and
  // form the broadcast control for the chain.
  always_comb begin
    st          = ST_DONE;
    count_next  = count;
    result_word = '0;
    ctl.ins     = 1'b0;
    ctl.del     = 1'b0;
    ctl.pos     = position;
    ctl.wdata   = data_in;
    unique case (op_t'(opcode))
      OP_INSERT: begin
        if (pos_c > cnt_c) begin
          st = ST_RANGE;
        end else if (cnt_c >= CAP_C) begin
          st = ST_FULL;
        end else begin
          ctl.ins    = accept;
          count_next = count + CNT_W'(1);
        end
      end
      OP_READ: begin
        if (pos_c >= cnt_c) begin
          st = ST_RANGE;
        end else begin
          result_word = rd_word;
        end
      end
      OP_DELETE: begin
        if (pos_c >= cnt_c) begin
          st = ST_RANGE;
        end else begin
          ctl.del    = accept;
          count_next = count - CNT_W'(1);
        end
      end
      default: begin
        st = ST_RANGE;
      end
    endcase
    if (st != ST_DONE) begin
      result_word = NOT_FOUND;
    end
  end

  // The chain of cells. The first cell sees the incoming word on its left and
  // the last cell sees itself on its right, so the ends stay well defined.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_W-1:0] left_d;
    logic [DATA_W-1:0] right_d;

    if (g == 0) begin : g_first
      assign left_d = data_in;
    end else begin : g_mid_l
      assign left_d = cell_q[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_d = cell_q[g];
    end else begin : g_mid_r
      assign right_d = cell_q[g+1];
    end

    isb_cell #(
      .INDEX (g),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .left_data  (left_d),
      .right_data (right_d),
      .value      (cell_q[g])
    );
  end

  // Entry count and output valid are control state and clear on reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload register, loaded with each accepted transaction.
  always_ff @(posedge clk) begin
    if (accept) begin
      status      <= st;
      data_out    <= result_word;
      entry_count <= COUNT_W'(count_next);
    end
  end

endmodule

// File: rtl/isb_cell.sv
// One storage cell of the sequence chain, holding the entry at a fixed index.
module isb_cell
  import isb_pkg::*;
#(
  parameter int INDEX = 0,
  parameter int IDX_W = POS_W
) (
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [DATA_W-1:0] left_data,
  input  logic [DATA_W-1:0] right_data,
  output logic [DATA_W-1:0] value
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [IDX_W-1:0] pos_ext;
  logic             at_pos;
  logic             after_pos;
  logic [DATA_W-1:0] value_next;

  assign pos_ext   = IDX_W'(ctl.pos);
  assign at_pos    = (MY_IDX == pos_ext);
  assign after_pos = (MY_IDX > pos_ext);

  // On insert the cell at the position takes the new word and later cells
  // take their left neighbor; on delete the cell at the position and later
  // ones take their right neighbor.
  always_comb begin
    value_next = value;
    priority if (ctl.ins) begin
      if (at_pos) begin
        value_next = ctl.wdata;
      end else if (after_pos) begin
        value_next = left_data;
      end
    end else if (ctl.del) begin
      if (at_pos || after_pos) begin
        value_next = right_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

// File: rtl/isb_checker.sv
// Port-level assertion checker for the indexed sequence buffer, with its bind.
`include "indexed_sequence_buffer_core_defines.svh"

module isb_checker
  import isb_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [1:0]               status,
  input logic signed [DATA_W-1:0] data_out,
  input logic [COUNT_W-1:0]       entry_count
);

  // Every accepted transaction shows its result in the following cycle.
  `ISB_ASSERT_NEXT(a_result_follows, clk, rst, in_valid && in_ready, out_valid, "no result after accept")

  // An empty output register never holds off the input.
  `ISB_ASSERT_IMPLY(a_ready_when_empty, clk, rst, !out_valid, in_ready, "input stalled while output empty")

  // Any failed operation reports a data word of all ones.
  `ISB_ASSERT_IMPLY(a_fail_word, clk, rst, out_valid && (status != ST_DONE), data_out == NOT_FOUND, "failed operation without all-ones data")

  // A stalled result holds its payload.
  `ISB_ASSERT_NEXT(a_hold_result, clk, rst, out_valid && !out_ready, out_valid && $stable(status) && $stable(data_out) && $stable(entry_count), "stalled result changed")

endmodule

bind indexed_sequence_buffer_core isb_checker u_isb_checker (.*);
